/* design/can_message_supervisor_defines.svh */
// ----------------------------------------------------------------------------
// CAN message supervisor assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef CAN_MESSAGE_SUPERVISOR_DEFINES_SVH
`define CAN_MESSAGE_SUPERVISOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define CMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cms_pkg.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor package
// Command, result and queue entry types shared by all supervisor modules.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_RX    = 2'd1;
  localparam logic [1:0] MODE_TX    = 2'd2;

  localparam int unsigned COUNT_W   = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] DEPTH_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_RX,
    OP_TX,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [10:0] can_id;
    logic [31:0] now;
    logic [31:0] last_time;
    logic [15:0] period;
    logic [7:0]  timeout_periods;
    logic        timeout_flag;
    logic        prev_tx_ok;
    logic        tx_allowed;
    logic        send_accepted;
  } cmd_t;

  typedef struct packed {
    logic        matched;
    logic [3:0]  match_slot;
    logic [31:0] new_last_time;
    logic        new_timeout_flag;
    logic        fail_event;
    logic        send_due;
    logic        refresh_payload;
    logic        new_tx_ok;
    logic [4:0]  pending_count;
  } rsp_t;

  typedef struct packed {
    op_t  op;
    cmd_t cmd;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

/* design/cms_front.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor front end
// Accepts commands, classifies them and hands them to the work queue.
// ----------------------------------------------------------------------------
module cms_front #(
  parameter int BUF_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cms_pkg::cmd_t      cmd,
  input  cms_pkg::q_status_t q_status,
  output logic               push,
  output cms_pkg::entry_t    push_entry
);
  import cms_pkg::*;

  logic   held;
  entry_t entry;
  op_t    op_class;
  logic   accept;

  // Stores outside the buffer leave no trace; treat them as no-ops.
  always_comb begin
    unique case (cmd.mode)
      MODE_STORE: op_class = (32'(cmd.slot) < BUF_DEPTH) ? OP_STORE : OP_NOP;
      MODE_RX:    op_class = OP_RX;
      MODE_TX:    op_class = OP_TX;
      default:    op_class = OP_NOP;
    endcase
  end

  assign push       = held && !q_status.full;
  assign busy       = held && q_status.full;
  assign accept     = start && !busy;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= (held && !push) || accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry.op  <= op_class;
      entry.cmd <= cmd;
    end
  end

endmodule

/* design/cms_queue.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor work queue
// Two-entry FIFO between the front end and the execution unit.
// ----------------------------------------------------------------------------
module cms_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cms_pkg::entry_t    push_entry,
  input  logic               pop,
  output cms_pkg::entry_t    pop_entry,
  output cms_pkg::q_status_t q_status
);
  import cms_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_entry      = slots[rd_ptr];
  assign q_status.valid = (count != 2'd0);
  assign q_status.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* design/cms_back.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor execution unit
// Owns the receive buffer and carries out store, receive and transmit work.
// ----------------------------------------------------------------------------
module cms_back #(
  parameter int BUF_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  cms_pkg::q_status_t q_status,
  output logic               pop,
  input  cms_pkg::entry_t    pop_entry,
  output logic               done,
  output cms_pkg::rsp_t      rsp
);
  import cms_pkg::*;

  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t               state;
  entry_t               cur;
  logic [10:0]          ids [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] marks;
  logic [COUNT_W-1:0]   total;
  logic [4:0]           search_depth;
  logic [BUF_DEPTH-1:0] hit_vec;
  logic [BUF_DEPTH-1:0] hit_next;
  logic [31:0]          elapsed;
  logic [23:0]          limit;
  logic [IDX_W-1:0]     store_idx;
  logic [IDX_W-1:0]     first_idx;
  logic                 any_hit;
  logic                 tx_due;
  logic                 rx_tmo;
  logic                 rx_flag;
  rsp_t                 pass_rsp;
  rsp_t                 exec_rsp;
  rsp_t                 fin_rsp;

  assign pop       = (state == S_IDLE) && q_status.valid;
  assign store_idx = IDX_W'(cur.cmd.slot);

  // Compare every slot against the serviced ID in parallel.
  always_comb begin
    for (int p = 0; p < BUF_DEPTH; p++) begin
      hit_next[p] = marks[p] && (ids[p] == cur.cmd.can_id) &&
                    (p < int'(search_depth)) && (total != '0);
    end
  end

  // Pick the lowest matching slot.
  always_comb begin
    first_idx = '0;
    for (int p = BUF_DEPTH - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        first_idx = IDX_W'(p);
      end
    end
  end

  assign any_hit = |hit_vec;
  assign tx_due  = (cur.cmd.period != 16'd0) && cur.cmd.tx_allowed &&
                   ((cur.cmd.now - cur.cmd.last_time) >= 32'(cur.cmd.period));
  // A hit restarts the cycle timer, so no timeout is raised on a hit.
  assign rx_tmo  = (cur.cmd.period != 16'd0) && !any_hit &&
                   (elapsed > 32'(limit));
  assign rx_flag = any_hit ? 1'b0 : cur.cmd.timeout_flag;

  always_comb begin
    pass_rsp                  = '0;
    pass_rsp.new_last_time    = cur.cmd.last_time;
    pass_rsp.new_timeout_flag = cur.cmd.timeout_flag;
    pass_rsp.new_tx_ok        = cur.cmd.prev_tx_ok;
    pass_rsp.pending_count    = total;
  end

  // Result of a store, transmit or no-op command.
  always_comb begin
    exec_rsp = pass_rsp;
    case (cur.op)
      OP_STORE: begin
        if (!marks[store_idx] && (total != COUNT_MAX)) begin
          exec_rsp.pending_count = total + COUNT_W'(1);
        end
      end
      OP_TX: begin
        if (tx_due) begin
          exec_rsp.send_due        = 1'b1;
          exec_rsp.refresh_payload = cur.cmd.prev_tx_ok;
          exec_rsp.new_tx_ok       = cur.cmd.send_accepted;
          if (cur.cmd.send_accepted) begin
            exec_rsp.new_last_time = cur.cmd.now;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result of a receive command.
  always_comb begin
    fin_rsp                  = pass_rsp;
    fin_rsp.new_timeout_flag = rx_flag || rx_tmo;
    fin_rsp.fail_event       = rx_tmo && !rx_flag;
    if (any_hit) begin
      fin_rsp.matched       = 1'b1;
      fin_rsp.match_slot    = 4'(first_idx);
      fin_rsp.new_last_time = cur.cmd.now;
      fin_rsp.pending_count = total - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      marks        <= '0;
      total        <= '0;
      search_depth <= DEPTH_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        search_depth <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (q_status.valid) begin
            cur   <= pop_entry;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          rsp   <= exec_rsp;
          state <= S_IDLE;
          unique case (cur.op)
            OP_STORE: begin
              if (!marks[store_idx]) begin
                marks[store_idx] <= 1'b1;
                if (total != COUNT_MAX) begin
                  total <= total + COUNT_W'(1);
                end
              end
              done <= 1'b1;
            end
            OP_TX: begin
              done <= 1'b1;
            end
            OP_RX: begin
              // Register the hit vector, elapsed time and timeout limit.
              hit_vec <= hit_next;
              elapsed <= cur.cmd.now - cur.cmd.last_time;
              limit   <= 24'(cur.cmd.period) * 24'(cur.cmd.timeout_periods);
              state   <= S_FINISH;
            end
            default: begin
              done <= 1'b1;
            end
          endcase
        end
        S_FINISH: begin
          rsp <= fin_rsp;
          if (any_hit) begin
            marks[first_idx] <= 1'b0;
            total            <= total - COUNT_W'(1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EXEC) && (cur.op == OP_STORE)) begin
      ids[store_idx] <= cur.cmd.can_id;
    end
  end

endmodule

/* design/can_message_supervisor.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor
// Receive buffer with pending marks plus receive and transmit cycle checks.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the command transfers at a
//   clock edge where start is high and busy is low. The mode field selects
//   a frame store, a receive object service or a transmit object service.
//   Result channel: each command yields exactly one result on rsp, shown for
//   one cycle with done high. The receiver cannot stall, so take it then.
//   Configuration: cfg_we writes cfg_data into the search depth; write only
//   while no command is in flight.
// Flow:
//   A front register takes the command, a two-entry queue holds it and the
//   execution unit runs it. The execution unit takes a store, transmit or
//   no-op command through its idle and execute states and a receive command
//   through idle, execute (compare) and finish (priority pick and update),
//   and takes no new command from the queue until it is back in idle.
// Reset:
//   rst clears all pending marks, the pending count and the queue, and sets
//   the search depth to 16. Stored IDs are not cleared.
// ----------------------------------------------------------------------------
module can_message_supervisor #(
  parameter int BUF_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cms_pkg::cmd_t cmd,
  output logic          done,
  output cms_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data
);
  import cms_pkg::*;

  q_status_t q_status;
  logic      push;
  entry_t    push_entry;
  logic      pop;
  entry_t    pop_entry;

  // Classify and hold the command until the queue has room.
  cms_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple acceptance from execution.
  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  // Run the command against the receive buffer and drive the result.
  cms_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .pop       (pop),
    .pop_entry (pop_entry),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

/* design/cms_checker.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor checker
// Port-level properties of the supervisor results, bound to the top level.
// ----------------------------------------------------------------------------
`include "can_message_supervisor_defines.svh"

module cms_checker (
  input logic          clk,
  input logic          rst,
  input logic          done,
  input cms_pkg::rsp_t rsp
);
  import cms_pkg::*;

  // A consumed frame restarts the cycle timer, so no timeout can follow.
  `CMS_ASSERT_NOW(a_match_no_timeout, done && rsp.matched, !rsp.new_timeout_flag && !rsp.fail_event, "timeout on matched frame")

  // Receive and transmit outcomes never mix in one result.
  `CMS_ASSERT_NOW(a_due_not_matched, done && rsp.send_due, !rsp.matched, "send due on a receive match")

  // Drop the slot number when nothing was consumed.
  `CMS_ASSERT_NOW(a_slot_zero, done && !rsp.matched, rsp.match_slot == 4'd0, "slot without match")

  `CMS_ASSERT_NOW(a_refresh_due, done && rsp.refresh_payload, rsp.send_due, "refresh without due frame")

  // Every command passes through idle before execute, so results never come back to back.
  `CMS_ASSERT_NEXT(a_done_gap, done, !done, "results in consecutive cycles")

endmodule

bind can_message_supervisor cms_checker u_cms_checker (
  .clk   (clk),
  .rst   (rst),
  .done  (done),
  .rsp   (rsp)
);

/* dv/cms_result_checker.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor result checker
// Mirrors the receive buffer and the cycle-time rules, predicts one result per
// command transfer and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
module cms_result_checker
  import cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        done,
  input  rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          in_flight
);

  localparam int SLOTS = 16;

  logic [10:0]        rx_ids [SLOTS];
  bit                 rx_pending [SLOTS];
  logic [COUNT_W-1:0] pending_total;
  logic [4:0]         depth_reg;
  rsp_t               expected_rsp_q [$];

  // Advance the buffer mirror by one command and return its result.
  function automatic rsp_t predict_service(input cmd_t c);
    rsp_t        r;
    logic [31:0] elapsed;
    logic [31:0] limit;
    int          span;
    int          p;
    bit          timed_out;
    r                  = '0;
    r.new_last_time    = c.last_time;
    r.new_timeout_flag = c.timeout_flag;
    r.new_tx_ok        = c.prev_tx_ok;
    case (op_t'(c.mode))
      OP_STORE: begin
        rx_ids[c.slot] = c.can_id;
        if (!rx_pending[c.slot]) begin
          rx_pending[c.slot] = 1'b1;
          if (pending_total != COUNT_MAX) pending_total++;
        end
      end
      OP_RX: begin
        span = (depth_reg > SLOTS) ? SLOTS : int'(depth_reg);
        if (pending_total != '0) begin
          for (p = 0; p < span; p++) begin
            if (!r.matched && rx_pending[p] && rx_ids[p] == c.can_id) begin
              rx_pending[p]      = 1'b0;
              pending_total--;
              r.matched          = 1'b1;
              r.match_slot       = p[3:0];
              r.new_timeout_flag = 1'b0;
              r.new_last_time    = c.now;
            end
          end
        end
        if (c.period != '0) begin
          elapsed   = c.now - r.new_last_time;
          limit     = 32'(c.period) * 32'(c.timeout_periods);
          timed_out = elapsed > limit;
          if (timed_out && !r.new_timeout_flag) r.fail_event = 1'b1;
          r.new_timeout_flag = r.new_timeout_flag | timed_out;
        end
      end
      OP_TX: begin
        elapsed = c.now - c.last_time;
        if (c.period != '0 && elapsed >= 32'(c.period) && c.tx_allowed) begin
          r.send_due        = 1'b1;
          r.refresh_payload = c.prev_tx_ok;
          r.new_tx_ok       = c.send_accepted;
          if (c.send_accepted) r.new_last_time = c.now;
        end
      end
      default: ;
    endcase
    r.pending_count = pending_total;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        rx_ids[i]     = '0;
        rx_pending[i] = 1'b0;
      end
      pending_total = '0;
      depth_reg     = DEPTH_RESET;
      expected_rsp_q.delete();
      fail_count    = 0;
      in_flight    <= 0;
    end else begin
      // Retire first: a result never belongs to a command taken at this edge.
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no command outstanding");
          fail_count++;
        end else begin
          e = expected_rsp_q.pop_front();
          check_field("matched",          32'(e.matched),          32'(rsp.matched));
          check_field("match_slot",       32'(e.match_slot),       32'(rsp.match_slot));
          check_field("new_last_time",    e.new_last_time,         rsp.new_last_time);
          check_field("new_timeout_flag", 32'(e.new_timeout_flag),
                      32'(rsp.new_timeout_flag));
          check_field("fail_event",       32'(e.fail_event),       32'(rsp.fail_event));
          check_field("send_due",         32'(e.send_due),         32'(rsp.send_due));
          check_field("refresh_payload",  32'(e.refresh_payload),
                      32'(rsp.refresh_payload));
          check_field("new_tx_ok",        32'(e.new_tx_ok),        32'(rsp.new_tx_ok));
          check_field("pending_count",    32'(e.pending_count),    32'(rsp.pending_count));
        end
      end
      if (cfg_we) depth_reg = cfg_data;
      if (start && !busy) expected_rsp_q.push_back(predict_service(cmd));
      in_flight <= expected_rsp_q.size();
    end
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// CAN message supervisor testbench
// Drives directed and random frame store, receive and transmit service
// commands in bursts, changes the search depth between phases and reports
// the verdict from the result checker's failure and in-flight counts.
// ----------------------------------------------------------------------------
module tb;
  import cms_pkg::*;

  localparam int PHASES     = 6;
  localparam int PHASE_CMDS = 255;
  localparam int DRAIN_MAX  = 400;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  cmd_t       cmd;
  logic       done;
  rsp_t       rsp;
  logic       cfg_we;
  logic [4:0] cfg_data;
  int         fail_count;
  int         in_flight;

  // IDs that arrivals and services share within one phase, so that
  // receive services actually find pending frames.
  logic [10:0] id_pool [4];

  can_message_supervisor #(
    .BUF_DEPTH (16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  cms_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bail out if the block stops answering or never frees its command port.
  initial begin
    #2000000;
    $display("** can_message_supervisor: FAILED **");
    $finish;
  end

  // Fill every field with random bits; callers then shape what matters.
  function automatic cmd_t random_cmd();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return cmd_t'(raw[$bits(cmd_t)-1:0]);
  endfunction

  // flags are {timeout_flag, prev_tx_ok, tx_allowed, send_accepted}.
  function automatic cmd_t make_cmd(input op_t op, input logic [3:0] slot,
                                    input logic [10:0] id, input logic [31:0] now,
                                    input logic [31:0] last, input logic [15:0] period,
                                    input logic [7:0] periods, input logic [3:0] flags);
    cmd_t c;
    c.mode            = op;
    c.slot            = slot;
    c.can_id          = id;
    c.now             = now;
    c.last_time       = last;
    c.period          = period;
    c.timeout_periods = periods;
    {c.timeout_flag, c.prev_tx_ok, c.tx_allowed, c.send_accepted} = flags;
    return c;
  endfunction

  // Build one random command. Most traffic stores and services IDs from the
  // shared pool, with times placed right around the timeout and due limits.
  function automatic cmd_t next_command();
    cmd_t        c;
    int unsigned pick;
    int          delta;
    logic [31:0] span;
    c     = random_cmd();
    pick  = $urandom_range(0, 99);
    delta = int'($urandom_range(0, 4)) - 2;
    if (pick < 36) begin
      c.mode = OP_STORE;
      if ($urandom_range(0, 9) != 0) c.can_id = id_pool[$urandom_range(0, 3)];
    end else if (pick < 70) begin
      c.mode = OP_RX;
      if ($urandom_range(0, 9) != 0) c.can_id = id_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 4) == 0) c.period = '0;
      else if ($urandom_range(0, 1) == 0) c.period = 16'($urandom_range(1, 20));
      if ($urandom_range(0, 3) != 0) begin
        span        = 32'(c.period) * 32'(c.timeout_periods);
        c.last_time = c.now - span - delta;
      end
    end else if (pick < 95) begin
      c.mode = OP_TX;
      if ($urandom_range(0, 6) == 0) c.period = '0;
      c.tx_allowed = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) != 0) c.last_time = c.now - 32'(c.period) - delta;
    end else begin
      c.mode = OP_NOP;
    end
    return c;
  endfunction

  // Present a command and hold it until it transfers. start stays high so
  // that back-to-back commands need no extra edge.
  task automatic send_cmd(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start and hold until every predicted result has come back.
  task automatic drain();
    int k;
    start <= 1'b0;
    for (k = 0; k < DRAIN_MAX && in_flight != 0; k++) @(posedge clk);
    @(posedge clk);
    for (k = 0; k < DRAIN_MAX && in_flight != 0; k++) @(posedge clk);
  endtask

  // Write the search depth; only call with nothing in flight.
  task automatic write_depth(input logic [4:0] depth);
    cfg_we   <= 1'b1;
    cfg_data <= depth;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    cmd_t       c;
    logic [4:0] depths [PHASES];
    int         burst_left;
    start    <= 1'b0;
    cmd      <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    rst      <= 1'b1;
    repeat (4) @(posedge clk);
    rst      <= 1'b0;

    // ---- Directed: empty buffer, arrivals and re-arrival -------------------
    send_cmd(make_cmd(OP_RX,    4'd0,  11'h2A5, 32'd100, 32'd90, 16'd0, 8'd0, 4'b0000));
    send_cmd(make_cmd(OP_STORE, 4'd0,  11'h7FF, 32'd0, 32'd0, 16'd0, 8'd0, 4'b0000));
    send_cmd(make_cmd(OP_STORE, 4'd15, 11'h000, 32'd0, 32'd0, 16'd0, 8'd0, 4'b0000));
    send_cmd(make_cmd(OP_STORE, 4'd5,  11'h123, 32'd0, 32'd0, 16'd0, 8'd0, 4'b0000));
    // Re-arrival on a pending slot: overwrite the ID, keep the count.
    send_cmd(make_cmd(OP_STORE, 4'd5,  11'h456, 32'd0, 32'd0, 16'd0, 8'd0, 4'b0000));

    // ---- Directed: receive hits, misses and timeout limits -----------------
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h456, 32'd1000, 32'd0, 16'd10, 8'd3, 4'b1000));
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h7FF, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 8'hFF,
                      4'b1111));
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h000, 32'd50, 32'd0, 16'd0, 8'd0, 4'b0000));
    // The overwritten ID is gone; a new timeout raises the failure event once.
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h123, 32'd5, 32'd0, 16'd1, 8'd0, 4'b0000));
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h123, 32'd5, 32'd0, 16'd1, 8'd0, 4'b1000));
    // Elapsed time across the wrap of the tick counter.
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h555, 32'd2, 32'hFFFF_FFF0, 16'd4, 8'd4, 4'b0000));
    // Elapsed exactly at the limit is not a timeout.
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h555, 32'd300, 32'd0, 16'd100, 8'd3, 4'b0000));
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h555, 32'd9999, 32'd0, 16'd0, 8'd1, 4'b1000));

    // ---- Directed: transmit due decisions ----------------------------------
    send_cmd(make_cmd(OP_TX, 4'd0, 11'h100, 32'd500, 32'd0, 16'd0, 8'd0, 4'b0111));
    send_cmd(make_cmd(OP_TX, 4'd0, 11'h100, 32'd600, 32'd500, 16'd100, 8'd0, 4'b0111));
    send_cmd(make_cmd(OP_TX, 4'd0, 11'h100, 32'd600, 32'd500, 16'd100, 8'd0, 4'b0010));
    send_cmd(make_cmd(OP_TX, 4'd0, 11'h100, 32'd600, 32'd500, 16'd100, 8'd0, 4'b0101));
    send_cmd(make_cmd(OP_TX, 4'd0, 11'h100, 32'd599, 32'd500, 16'd100, 8'd0, 4'b0111));
    send_cmd(make_cmd(OP_TX, 4'd0, 11'h100, 32'd5, 32'hFFFF_FFFA, 16'd11, 8'd0, 4'b0111));

    // ---- Directed: unused mode and all-ones / all-zero commands ------------
    send_cmd('1);
    c      = '1;
    c.mode = OP_STORE;
    send_cmd(c);
    send_cmd('0);

    // ---- Directed: search depth zero, one and beyond the buffer ------------
    // Slot 0 holds ID 0 and slot 15 holds ID 0x7FF, both pending.
    drain();
    write_depth(5'd0);
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h000, 32'd10, 32'd10, 16'd0, 8'd0, 4'b0000));
    drain();
    write_depth(5'd1);
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h7FF, 32'd10, 32'd10, 16'd0, 8'd0, 4'b0000));
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h000, 32'd10, 32'd10, 16'd0, 8'd0, 4'b0000));
    drain();
    write_depth(5'd31);
    send_cmd(make_cmd(OP_RX, 4'd0, 11'h7FF, 32'd10, 32'd10, 16'd0, 8'd0, 4'b0000));

    // ---- Random phases, one search depth each ------------------------------
    depths[0] = 5'd16;
    depths[1] = 5'd31;
    depths[2] = 5'd2;
    depths[3] = 5'($urandom_range(0, 31));
    depths[4] = 5'd1;
    depths[5] = 5'($urandom_range(3, 15));
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_depth(depths[ph]);
      for (int i = 0; i < 4; i++) id_pool[i] = 11'($urandom_range(0, 2047));
      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        send_cmd(next_command());
        burst_left--;
        // Phase 2 runs with no gaps at all; the others idle between bursts.
        if (burst_left == 0) begin
          if (ph != 2) idle_cycles($urandom_range(0, 8));
          burst_left = $urandom_range(1, 20);
        end
      end
    end

    // ---- Wind down ---------------------------------------------------------
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("** can_message_supervisor: PASSED **");
    end else begin
      if (in_flight != 0) $error("%0d results never arrived", in_flight);
      $display("** can_message_supervisor: FAILED **");
    end
    $finish;
  end

endmodule
